### src/rcht_pkg.sv
// shared types and constants of the resizing chained hash table
`default_nettype none
package rcht_pkg;

  localparam int CommandW   = 1;
  localparam int StampW     = 31;
  localparam int AddressW   = 32;
  localparam int StatusW    = 2;
  localparam int BucketIdxW = 8;
  localparam int BucketCntW = 4;
  localparam int PositionW  = 3;
  localparam int CfgIndexW  = 1;
  localparam int CfgDataW   = 8;
  localparam int InitSizeW  = 8;
  localparam int LoadFactW  = 4;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_GROW   = 2'd3
  } status_t;

  localparam logic [CommandW-1:0] CMD_INSERT = 1'b0;
  localparam logic [CommandW-1:0] CMD_QUERY  = 1'b1;

  localparam logic [CfgIndexW-1:0] CFG_INITIAL_SIZE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_LOAD_FACTOR  = 1'b1;

  localparam logic [InitSizeW-1:0] INIT_SIZE_RST = 8'd7;
  localparam logic [LoadFactW-1:0] LOAD_FACT_RST = 4'd2;

endpackage
`default_nettype wire

### src/rcht_ifs.sv
// channel interfaces of the resizing chained hash table
`default_nettype none
interface rcht_in_if;
  logic                           valid;
  logic                           ready;
  logic [rcht_pkg::CommandW-1:0]  command;
  logic [rcht_pkg::StampW-1:0]    stamp;
  logic [rcht_pkg::AddressW-1:0]  client_address;
  modport source (output valid, command, stamp, client_address, input ready);
  modport sink   (input valid, command, stamp, client_address, output ready);
endinterface

interface rcht_out_if;
  logic                            valid;
  logic                            ready;
  logic [rcht_pkg::StatusW-1:0]    status;
  logic [rcht_pkg::BucketIdxW-1:0] bucket_index;
  logic [rcht_pkg::BucketCntW-1:0] bucket_count;
  logic [rcht_pkg::AddressW-1:0]   found_address;
  logic [rcht_pkg::PositionW-1:0]  found_position;
  modport source (output valid, status, bucket_index, bucket_count, found_address,
                  found_position, input ready);
  modport sink   (input valid, status, bucket_index, bucket_count, found_address,
                  found_position, output ready);
endinterface

interface rcht_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rcht_pkg::CfgIndexW-1:0] index;
  logic [rcht_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/resizing_chained_hash_table.sv
// query: bit-serial key mod table size, fill read, then binary search probes; insert: mod, fill read, sorted placement
// an insert over the load limit first grows: clear the target bank's fill counts, then rehash each old entry
// throughput: one transaction at a time, next accepted once the result sits in the output register
// the entry memory, with one read and one write port, and the bit-serial mod unit set the pace
// reset: synchronous active-low, table empty with initial_size 7 and load_factor 2
// after reset a clearing pass over MAX_BUCKETS buckets zeroes the live bank's fill counts, input not ready meanwhile
`default_nettype none
module resizing_chained_hash_table #(
  parameter int MAX_BUCKETS  = 255,
  parameter int BUCKET_DEPTH = 8,
  parameter int KEY_BITS     = 31
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rcht_in_if.sink     in_chan,
  rcht_out_if.source  out_chan,
  rcht_cfg_if.sink    cfg_chan
);

  // widths derived from the sizing parameters
  localparam int SW        = $clog2(MAX_BUCKETS + 1);          // table size
  localparam int BW        = $clog2(MAX_BUCKETS);              // bucket index
  localparam int FW        = $clog2(BUCKET_DEPTH + 1);         // bucket fill
  localparam int PW        = $clog2(BUCKET_DEPTH);             // slot position
  localparam int ETW       = $clog2(MAX_BUCKETS * BUCKET_DEPTH + 1);
  localparam int MW        = (ETW > SW + rcht_pkg::LoadFactW) ? ETW : SW + rcht_pkg::LoadFactW;
  localparam int BankSlots = MAX_BUCKETS * BUCKET_DEPTH;
  localparam int SAW       = $clog2(2 * BankSlots);
  localparam int FAW       = $clog2(2 * MAX_BUCKETS);
  localparam int CW        = $clog2(KEY_BITS);

  typedef struct packed {
    logic [KEY_BITS-1:0]              key;
    logic [rcht_pkg::AddressW-1:0]    ip;
  } entry_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DIV,
    S_I_FILLRD, S_I_FILLCK, S_I_FIN,
    S_P_RD, S_P_CMP,
    S_G_START, S_G_CLR, S_G_BFILL, S_G_BCK, S_G_ENT, S_G_ENTD, S_G_SFRD, S_G_SFCK, S_G_RFIN,
    S_Q_FILLRD, S_Q_FILLCK, S_Q_PROBE, S_Q_CMP,
    S_DONE
  } state_t;

  function automatic logic [SAW-1:0] st_addr(input logic bank, input logic [BW-1:0] b,
                                             input logic [PW-1:0] p);
    return SAW'(bank) * SAW'(BankSlots) + SAW'(b) * SAW'(BUCKET_DEPTH) + SAW'(p);
  endfunction

  function automatic logic [FAW-1:0] fill_addr(input logic bank, input logic [BW-1:0] b);
    return FAW'(bank) * FAW'(MAX_BUCKETS) + FAW'(b);
  endfunction

  function automatic logic [SW-1:0] clamp_size(input logic [rcht_pkg::InitSizeW-1:0] v);
    logic [SW+rcht_pkg::InitSizeW-1:0] w;
    w = (SW + rcht_pkg::InitSizeW)'(v);
    if (v == '0) return SW'(1);
    if (w > (SW + rcht_pkg::InitSizeW)'(MAX_BUCKETS)) return SW'(MAX_BUCKETS);
    return SW'(v);
  endfunction

  // control and state
  state_t                          state_r;
  state_t                          div_ret_r;
  state_t                          p_ret_r;
  logic                            cur_bank_r;
  logic [SW-1:0]                   table_size_r;
  logic [SW-1:0]                   new_size_r;
  logic [ETW-1:0]                  entry_total_r;
  logic [rcht_pkg::InitSizeW-1:0]  init_size_r;
  logic [rcht_pkg::LoadFactW-1:0]  load_fact_r;
  logic [BW-1:0]                   clr_bkt_r;
  logic                            out_valid_r;

  // serial remainder unit
  logic [SW-1:0]                   div_rem_r;
  logic [KEY_BITS-1:0]             div_dvd_r;
  logic [SW-1:0]                   div_dvs_r;
  logic [CW-1:0]                   div_cnt_r;
  logic [SW:0]                     div_trial;
  logic [SW-1:0]                   div_rem_nxt;

  // transaction and walk registers
  logic [KEY_BITS-1:0]             op_key_r;
  logic [rcht_pkg::AddressW-1:0]   op_ip_r;
  logic [BW-1:0]                   bucket_r;
  logic                            p_bank_r;
  logic [BW-1:0]                   p_bkt_r;
  logic [KEY_BITS-1:0]             p_key_r;
  logic [rcht_pkg::AddressW-1:0]   p_ip_r;
  logic [FW-1:0]                   p_fill_r;
  logic [PW-1:0]                   p_pos_r;
  logic [SW-1:0]                   g_b_r;
  logic [FW-1:0]                   g_fill_r;
  logic [FW-1:0]                   g_j_r;
  logic [FW-1:0]                   lo_r;
  logic [FW-1:0]                   hi_r;
  logic [PW-1:0]                   mid_r;
  logic [PW-1:0]                   mid_c;

  // result held until the output register is free
  rcht_pkg::status_t               res_status_r;
  logic [BW-1:0]                   res_bucket_r;
  logic [FW-1:0]                   res_count_r;
  logic [rcht_pkg::AddressW-1:0]   res_addr_r;
  logic [PW-1:0]                   res_pos_r;

  logic [rcht_pkg::StatusW-1:0]    out_status_r;
  logic [rcht_pkg::BucketIdxW-1:0] out_bucket_r;
  logic [rcht_pkg::BucketCntW-1:0] out_count_r;
  logic [rcht_pkg::AddressW-1:0]   out_addr_r;
  logic [rcht_pkg::PositionW-1:0]  out_pos_r;

  // entry memory: two banks, one holds the live table, the other is the rehash target
  entry_t                          st_mem_r [2*BankSlots];
  entry_t                          st_rd_r;
  logic                            st_we;
  logic [SAW-1:0]                  st_waddr;
  logic [SAW-1:0]                  st_raddr;
  entry_t                          st_wdata;

  // fill memory: one count per bucket and bank, zeroed by the clearing passes
  logic [FW-1:0]                   fill_mem_r [2*MAX_BUCKETS];
  logic [FW-1:0]                   fill_rd_r;
  logic                            f_we;
  logic                            f_wbank;
  logic [BW-1:0]                   f_wbkt;
  logic [FW-1:0]                   f_wdata;
  logic                            f_rbank;
  logic [BW-1:0]                   f_rbkt;
  logic [FW-1:0]                   fill_eff;

  logic [rcht_pkg::LoadFactW-1:0]  lf_eff;
  logic [SW:0]                     grow_size;
  logic                            in_fire;
  logic                            out_free;

  assign in_chan.ready   = (state_r == S_IDLE);
  assign cfg_chan.ready  = 1'b1;
  assign in_fire         = in_chan.valid && (state_r == S_IDLE);
  assign out_free        = !out_valid_r || out_chan.ready;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.bucket_index   = out_bucket_r;
  assign out_chan.bucket_count   = out_count_r;
  assign out_chan.found_address  = out_addr_r;
  assign out_chan.found_position = out_pos_r;

  assign lf_eff    = (load_fact_r == '0) ? rcht_pkg::LoadFactW'(1) : load_fact_r;
  assign grow_size = {table_size_r, 1'b1};
  assign fill_eff  = fill_rd_r;
  assign mid_c     = PW'(((FW+1)'(lo_r) + (FW+1)'(hi_r) - (FW+1)'(1)) >> 1);

  // one restoring step of key mod divisor per cycle
  assign div_trial   = {div_rem_r, div_dvd_r[KEY_BITS-1]};
  assign div_rem_nxt = (div_trial >= {1'b0, div_dvs_r}) ? SW'(div_trial - {1'b0, div_dvs_r})
                                                       : SW'(div_trial);

  // memory port steering
  always_comb begin
    st_we    = 1'b0;
    st_waddr = st_addr(p_bank_r, p_bkt_r, p_pos_r);
    st_wdata = '{key: p_key_r, ip: p_ip_r};
    st_raddr = st_addr(p_bank_r, p_bkt_r, PW'(p_pos_r - PW'(1)));
    f_we     = 1'b0;
    f_wbank  = cur_bank_r;
    f_wbkt   = p_bkt_r;
    f_wdata  = FW'(p_fill_r + FW'(1));
    f_rbank  = cur_bank_r;
    f_rbkt   = BW'(div_rem_r);
    case (state_r)
      S_CLR: begin
        f_we    = 1'b1;
        f_wbkt  = clr_bkt_r;
        f_wdata = '0;
      end
      S_G_CLR: begin
        f_we    = 1'b1;
        f_wbank = !cur_bank_r;
        f_wbkt  = clr_bkt_r;
        f_wdata = '0;
      end
      S_P_RD: begin
        // empty slot at the bottom of the bucket: new entry lands there
        if (p_pos_r == '0) st_we = 1'b1;
      end
      S_P_CMP: begin
        st_we = 1'b1;
        if (st_rd_r.key > p_key_r) st_wdata = st_rd_r;
      end
      S_G_BFILL: f_rbkt = BW'(g_b_r);
      S_G_ENT:   st_raddr = st_addr(cur_bank_r, BW'(g_b_r), PW'(g_j_r));
      S_G_SFRD:  f_rbank = !cur_bank_r;
      S_Q_PROBE: st_raddr = st_addr(cur_bank_r, bucket_r, mid_c);
      S_I_FIN:   f_we = 1'b1;
      S_G_RFIN: begin
        f_we    = 1'b1;
        f_wbank = !cur_bank_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem_r[st_waddr] <= st_wdata;
    st_rd_r <= st_mem_r[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) fill_mem_r[fill_addr(f_wbank, f_wbkt)] <= f_wdata;
    fill_rd_r <= fill_mem_r[fill_addr(f_rbank, f_rbkt)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_bkt_r     <= '0;
      cur_bank_r    <= 1'b0;
      init_size_r   <= rcht_pkg::INIT_SIZE_RST;
      load_fact_r   <= rcht_pkg::LOAD_FACT_RST;
      table_size_r  <= clamp_size(rcht_pkg::INIT_SIZE_RST);
      entry_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;

      // configuration writes; size takes effect only on an empty table
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          rcht_pkg::CFG_INITIAL_SIZE: begin
            init_size_r <= cfg_chan.data;
            if (entry_total_r == '0) table_size_r <= clamp_size(cfg_chan.data);
          end
          rcht_pkg::CFG_LOAD_FACTOR: load_fact_r <= rcht_pkg::LoadFactW'(cfg_chan.data);
          default: ;
        endcase
      end

      case (state_r)
        // clearing pass over the live bank's fill counts
        S_CLR: begin
          if (clr_bkt_r == BW'(MAX_BUCKETS - 1)) state_r <= S_IDLE;
          else clr_bkt_r <= BW'(clr_bkt_r + BW'(1));
        end
        S_IDLE: begin
          if (in_fire) begin
            op_key_r     <= KEY_BITS'(in_chan.stamp);
            op_ip_r      <= in_chan.client_address;
            res_bucket_r <= '0;
            res_count_r  <= '0;
            res_addr_r   <= '0;
            res_pos_r    <= '0;
            div_dvd_r    <= KEY_BITS'(in_chan.stamp);
            div_dvs_r    <= table_size_r;
            div_rem_r    <= '0;
            div_cnt_r    <= '0;
            if (in_chan.command == rcht_pkg::CMD_INSERT) begin
              div_ret_r <= S_I_FILLRD;
              if (MW'(entry_total_r) > MW'(table_size_r) * MW'(lf_eff)) state_r <= S_G_START;
              else state_r <= S_DIV;
            end else begin
              div_ret_r <= S_Q_FILLRD;
              state_r   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_dvd_r <= {div_dvd_r[KEY_BITS-2:0], 1'b0};
          div_cnt_r <= CW'(div_cnt_r + CW'(1));
          if (div_cnt_r == CW'(KEY_BITS - 1)) state_r <= div_ret_r;
        end
        // insert path
        S_I_FILLRD: begin
          bucket_r <= BW'(div_rem_r);
          state_r  <= S_I_FILLCK;
        end
        S_I_FILLCK: begin
          res_bucket_r <= bucket_r;
          if (fill_eff >= FW'(BUCKET_DEPTH)) begin
            res_status_r <= rcht_pkg::ST_FULL;
            res_count_r  <= fill_eff;
            state_r      <= S_DONE;
          end else begin
            p_bank_r <= cur_bank_r;
            p_bkt_r  <= bucket_r;
            p_key_r  <= op_key_r;
            p_ip_r   <= op_ip_r;
            p_fill_r <= fill_eff;
            p_pos_r  <= PW'(fill_eff);
            p_ret_r  <= S_I_FIN;
            state_r  <= S_P_RD;
          end
        end
        S_I_FIN: begin
          entry_total_r <= ETW'(entry_total_r + ETW'(1));
          res_status_r  <= rcht_pkg::ST_OK;
          res_count_r   <= FW'(p_fill_r + FW'(1));
          state_r       <= S_DONE;
        end
        // sorted placement: walk down, shifting larger keys up one slot
        S_P_RD: begin
          if (p_pos_r == '0) state_r <= p_ret_r;
          else state_r <= S_P_CMP;
        end
        S_P_CMP: begin
          if (st_rd_r.key > p_key_r) begin
            p_pos_r <= PW'(p_pos_r - PW'(1));
            state_r <= S_P_RD;
          end else begin
            state_r <= p_ret_r;
          end
        end
        // growth: rehash the live bank into the other bank, swap on success
        S_G_START: begin
          if (grow_size > (SW+1)'(MAX_BUCKETS)) begin
            res_status_r <= rcht_pkg::ST_NO_GROW;
            state_r      <= S_DONE;
          end else begin
            new_size_r <= SW'(grow_size);
            g_b_r      <= '0;
            clr_bkt_r  <= '0;
            state_r    <= S_G_CLR;
          end
        end
        // zero the target bank's fill counts for the new size
        S_G_CLR: begin
          if (clr_bkt_r == BW'(new_size_r - SW'(1))) state_r <= S_G_BFILL;
          else clr_bkt_r <= BW'(clr_bkt_r + BW'(1));
        end
        S_G_BFILL: begin
          if (g_b_r == table_size_r) begin
            cur_bank_r   <= !cur_bank_r;
            table_size_r <= new_size_r;
            div_dvd_r    <= op_key_r;
            div_dvs_r    <= new_size_r;
            div_rem_r    <= '0;
            div_cnt_r    <= '0;
            div_ret_r    <= S_I_FILLRD;
            state_r      <= S_DIV;
          end else begin
            state_r <= S_G_BCK;
          end
        end
        S_G_BCK: begin
          g_fill_r <= fill_eff;
          g_j_r    <= '0;
          state_r  <= S_G_ENT;
        end
        S_G_ENT: begin
          if (g_j_r == g_fill_r) begin
            g_b_r   <= SW'(g_b_r + SW'(1));
            state_r <= S_G_BFILL;
          end else begin
            state_r <= S_G_ENTD;
          end
        end
        S_G_ENTD: begin
          p_key_r   <= st_rd_r.key;
          p_ip_r    <= st_rd_r.ip;
          div_dvd_r <= st_rd_r.key;
          div_dvs_r <= new_size_r;
          div_rem_r <= '0;
          div_cnt_r <= '0;
          div_ret_r <= S_G_SFRD;
          state_r   <= S_DIV;
        end
        S_G_SFRD: begin
          p_bkt_r <= BW'(div_rem_r);
          state_r <= S_G_SFCK;
        end
        S_G_SFCK: begin
          if (fill_eff >= FW'(BUCKET_DEPTH)) begin
            // a new bucket overflows: table stays as it was
            res_status_r <= rcht_pkg::ST_NO_GROW;
            state_r      <= S_DONE;
          end else begin
            p_bank_r <= !cur_bank_r;
            p_fill_r <= fill_eff;
            p_pos_r  <= PW'(fill_eff);
            p_ret_r  <= S_G_RFIN;
            state_r  <= S_P_RD;
          end
        end
        S_G_RFIN: begin
          g_j_r   <= FW'(g_j_r + FW'(1));
          state_r <= S_G_ENT;
        end
        // query path: binary search over the sorted bucket
        S_Q_FILLRD: begin
          bucket_r <= BW'(div_rem_r);
          state_r  <= S_Q_FILLCK;
        end
        S_Q_FILLCK: begin
          res_bucket_r <= bucket_r;
          res_count_r  <= fill_eff;
          lo_r         <= '0;
          hi_r         <= fill_eff;
          state_r      <= S_Q_PROBE;
        end
        S_Q_PROBE: begin
          if (lo_r >= hi_r) begin
            res_status_r <= rcht_pkg::ST_NOT_FOUND;
            state_r      <= S_DONE;
          end else begin
            mid_r   <= mid_c;
            state_r <= S_Q_CMP;
          end
        end
        S_Q_CMP: begin
          if (st_rd_r.key == op_key_r) begin
            res_status_r <= rcht_pkg::ST_OK;
            res_addr_r   <= st_rd_r.ip;
            res_pos_r    <= mid_r;
            state_r      <= S_DONE;
          end else begin
            if (st_rd_r.key > op_key_r) hi_r <= FW'(mid_r);
            else lo_r <= FW'(FW'(mid_r) + FW'(1));
            state_r <= S_Q_PROBE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_bucket_r <= rcht_pkg::BucketIdxW'(res_bucket_r);
            out_count_r  <= rcht_pkg::BucketCntW'(res_count_r);
            out_addr_r   <= res_addr_r;
            out_pos_r    <= rcht_pkg::PositionW'(res_pos_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // bucket count stays within the memory's bucket range
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (table_size_r != '0) && (table_size_r <= SW'(MAX_BUCKETS)))
    else $error("table size out of range");

  // at most one entry is added per cycle and entries never vanish
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_total_r == $past(entry_total_r)) ||
    (entry_total_r == ETW'($past(entry_total_r) + ETW'(1))))
    else $error("entry total jumped");

  // remainder unit never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_dvs_r != '0))
    else $error("mod by zero");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
// self-checking testbench of the resizing chained hash table
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int NumBuckets = 255;
  localparam int Depth      = 8;
  localparam int StallLimit = 400000;   // long enough to cover the rehash of a full table
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 175;
  localparam int DrainPause = 200;

  typedef struct packed {
    logic [rcht_pkg::StatusW-1:0]    status;
    logic [rcht_pkg::BucketIdxW-1:0] bucket_index;
    logic [rcht_pkg::BucketCntW-1:0] bucket_count;
    logic [rcht_pkg::AddressW-1:0]   found_address;
    logic [rcht_pkg::PositionW-1:0]  found_position;
  } lookup_t;

  typedef struct {
    logic [rcht_pkg::CommandW-1:0] command;
    logic [rcht_pkg::StampW-1:0]   stamp;
    logic [rcht_pkg::AddressW-1:0] address;
    bit                            pinned;
    lookup_t                       result;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rcht_in_if  in_chan ();
  rcht_out_if out_chan ();
  rcht_cfg_if cfg_chan ();

  resizing_chained_hash_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source),
    .cfg_chan(cfg_chan.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // table shadow: own copy of buckets, size and registers
  // ---------------------------------------------------------------------------
  logic [rcht_pkg::InitSizeW-1:0] shadow_init_size;
  logic [rcht_pkg::LoadFactW-1:0] shadow_load;
  int unsigned                    shadow_size;
  int unsigned                    shadow_total;
  int unsigned                    fill  [NumBuckets];
  logic [rcht_pkg::StampW-1:0]    keys  [NumBuckets][Depth];
  logic [rcht_pkg::AddressW-1:0]  addrs [NumBuckets][Depth];
  int unsigned                    tmp_fill  [NumBuckets];
  logic [rcht_pkg::StampW-1:0]    tmp_keys  [NumBuckets][Depth];
  logic [rcht_pkg::AddressW-1:0]  tmp_addrs [NumBuckets][Depth];

  logic [rcht_pkg::StampW-1:0] used_stamps[$];
  lookup_t                     pending_results[$];

  function automatic int unsigned clamp_size(logic [rcht_pkg::InitSizeW-1:0] v);
    if (v == 0) return 1;
    if (v > NumBuckets) return NumBuckets;
    return 32'(v);
  endfunction

  // rehash into 2m+1 buckets; returns 0 and leaves the table alone on overflow
  function automatic bit grow_table();
    int unsigned nsize, b, j, nb, p, i;
    logic [rcht_pkg::StampW-1:0] k;
    nsize = 2 * shadow_size + 1;
    if (nsize > NumBuckets) return 0;
    foreach (tmp_fill[x]) tmp_fill[x] = 0;
    for (b = 0; b < shadow_size; b++) begin
      for (j = 0; j < fill[b]; j++) begin
        k  = keys[b][j];
        nb = 32'(k) % nsize;
        if (tmp_fill[nb] >= Depth) return 0;
        p = 0;
        while (p < tmp_fill[nb] && tmp_keys[nb][p] <= k) p++;
        for (i = tmp_fill[nb]; i > p; i--) begin
          tmp_keys[nb][i]  = tmp_keys[nb][i-1];
          tmp_addrs[nb][i] = tmp_addrs[nb][i-1];
        end
        tmp_keys[nb][p]  = k;
        tmp_addrs[nb][p] = addrs[b][j];
        tmp_fill[nb]++;
      end
    end
    keys = tmp_keys;
    addrs = tmp_addrs;
    fill = tmp_fill;
    shadow_size = nsize;
    return 1;
  endfunction

  function automatic lookup_t table_step(logic [rcht_pkg::CommandW-1:0] cmd,
                                         logic [rcht_pkg::StampW-1:0] key,
                                         logic [rcht_pkg::AddressW-1:0] ip);
    lookup_t r;
    int unsigned lf, b, cnt, p, i, lo, hi, mid;
    r = '0;
    if (cmd == rcht_pkg::CMD_INSERT) begin
      lf = (shadow_load == 0) ? 1 : 32'(shadow_load);
      if (shadow_total > shadow_size * lf && !grow_table()) begin
        r.status = rcht_pkg::ST_NO_GROW;
        return r;
      end
      b = 32'(key) % shadow_size;
      cnt = fill[b];
      r.bucket_index = rcht_pkg::BucketIdxW'(b);
      r.bucket_count = rcht_pkg::BucketCntW'(cnt);
      if (cnt >= Depth) begin
        r.status = rcht_pkg::ST_FULL;
        return r;
      end
      // equal stamps go after the ones already there
      p = 0;
      while (p < cnt && keys[b][p] <= key) p++;
      for (i = cnt; i > p; i--) begin
        keys[b][i]  = keys[b][i-1];
        addrs[b][i] = addrs[b][i-1];
      end
      keys[b][p]  = key;
      addrs[b][p] = ip;
      fill[b] = cnt + 1;
      shadow_total++;
      r.status = rcht_pkg::ST_OK;
      r.bucket_count = rcht_pkg::BucketCntW'(cnt + 1);
    end else begin
      b = 32'(key) % shadow_size;
      cnt = fill[b];
      r.bucket_index = rcht_pkg::BucketIdxW'(b);
      r.bucket_count = rcht_pkg::BucketCntW'(cnt);
      r.status = rcht_pkg::ST_NOT_FOUND;
      lo = 0;
      hi = cnt;
      while (lo < hi) begin
        mid = (lo + hi - 1) / 2;
        if (keys[b][mid] == key) begin
          r.status = rcht_pkg::ST_OK;
          r.found_address = addrs[b][mid];
          r.found_position = rcht_pkg::PositionW'(mid);
          break;
        end
        if (keys[b][mid] > key) hi = mid;
        else lo = mid + 1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predicts on input transactions, checks output transactions
  // ---------------------------------------------------------------------------
  bit      cur_pinned;     // the item on the input channel has a typed-in result
  lookup_t cur_result;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      out_stall;
  int      idle_mode;      // 0 none, 1 sender idles, 2 receiver stalls, 3 both

  always @(posedge clk) begin
    lookup_t got, want, calc;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_chan.valid && cfg_chan.ready) begin
        moved = 1'b1;
        if (cfg_chan.index == rcht_pkg::CFG_INITIAL_SIZE) begin
          shadow_init_size = cfg_chan.data;
          if (shadow_total == 0) shadow_size = clamp_size(cfg_chan.data);
        end else begin
          shadow_load = cfg_chan.data[rcht_pkg::LoadFactW-1:0];
        end
      end
      if (out_chan.valid && out_chan.ready) begin
        moved = 1'b1;
        got = {out_chan.status, out_chan.bucket_index, out_chan.bucket_count,
               out_chan.found_address, out_chan.found_position};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected st=%0d bkt=%0d cnt=%0d ip=%h pos=%0d,",
                        " got st=%0d bkt=%0d cnt=%0d ip=%h pos=%0d"},
                       want.status, want.bucket_index, want.bucket_count,
                       want.found_address, want.found_position,
                       got.status, got.bucket_index, got.bucket_count,
                       got.found_address, got.found_position);
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        moved = 1'b1;
        calc = table_step(in_chan.command, in_chan.stamp, in_chan.client_address);
        pending_results.push_back(cur_pinned ? cur_result : calc);
      end
      if (moved) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // receiver stalls according to the idling mode
  always @(negedge clk) begin
    out_stall = (idle_mode == 2) ? ($urandom_range(99) < 62) :
                (idle_mode == 3) ? ($urandom_range(99) < 10) : 1'b0;
    out_chan.ready <= rst_n && !out_stall;
  end

  // ---------------------------------------------------------------------------
  // drivers: everything changes at the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(step_t s);
    int pct;
    pct = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 10 : 0;
    @(negedge clk);
    while ($urandom_range(99) < pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.command        <= s.command;
    in_chan.stamp          <= s.stamp;
    in_chan.client_address <= s.address;
    cur_pinned = s.pinned;
    cur_result = s.result;
    do @(posedge clk); while (!in_chan.ready);
    if (s.command == rcht_pkg::CMD_INSERT) used_stamps.push_back(s.stamp);
  endtask

  task automatic write_reg(logic [rcht_pkg::CfgIndexW-1:0] idx,
                           logic [rcht_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    in_chan.valid  <= 1'b0;
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // hold off until every expected result is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainPause) @(posedge clk);
  endtask

  function automatic step_t make_row(logic [rcht_pkg::CommandW-1:0] c,
                                     logic [rcht_pkg::StampW-1:0] s,
                                     logic [rcht_pkg::AddressW-1:0] a, bit pin, lookup_t r);
    step_t row;
    row.command = c;
    row.stamp = s;
    row.address = a;
    row.pinned = pin;
    row.result = r;
    return row;
  endfunction

  function automatic step_t random_item();
    step_t row;
    int pick;
    row.command = ($urandom_range(99) < 65) ? rcht_pkg::CMD_INSERT : rcht_pkg::CMD_QUERY;
    row.address = $urandom;
    pick = $urandom_range(99);
    if (pick < 35 || used_stamps.size() == 0) row.stamp = rcht_pkg::StampW'($urandom);
    else if (pick < 55) row.stamp = rcht_pkg::StampW'($urandom_range(600));
    else if (pick < 63) row.stamp = ($urandom_range(1) != 0) ? '1 : '0;
    else row.stamp = used_stamps[$urandom_range(used_stamps.size() - 1)];
    row.pinned = 1'b0;
    row.result = '0;
    return row;
  endfunction

  step_t directed[$];
  lookup_t nil = '0;
  logic [rcht_pkg::LoadFactW-1:0] phase_load[NumPhases] =
    '{4'd0, 4'd1, 4'd1, 4'd8, 4'd15, 4'd2, 4'd1, 4'd4};

  initial begin
    in_chan.valid = 1'b0;
    in_chan.command = rcht_pkg::CMD_INSERT;
    in_chan.stamp = '0;
    in_chan.client_address = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = rcht_pkg::CFG_INITIAL_SIZE;
    cfg_chan.data = '0;
    idle_mode = 0;
    cur_pinned = 1'b0;
    cur_result = '0;
    shadow_init_size = rcht_pkg::INIT_SIZE_RST;
    shadow_load = rcht_pkg::LOAD_FACT_RST;
    shadow_size = clamp_size(rcht_pkg::INIT_SIZE_RST);
    shadow_total = 0;
    foreach (fill[x]) fill[x] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: size register takes effect, zero clamps to a single bucket
    write_reg(rcht_pkg::CFG_INITIAL_SIZE, 8'd255);
    write_reg(rcht_pkg::CFG_INITIAL_SIZE, 8'd0);
    write_reg(rcht_pkg::CFG_LOAD_FACTOR, 8'd15);

    // directed: one bucket, fill it, overflow it, search it
    directed.push_back(make_row(rcht_pkg::CMD_QUERY, 31'd5, 32'h0, 1,
                                '{rcht_pkg::ST_NOT_FOUND, 0, 0, 0, 0}));
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, 31'd0, '1, 1,
                                '{rcht_pkg::ST_OK, 0, 1, 0, 0}));
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, '1, 32'h0, 1,
                                '{rcht_pkg::ST_OK, 0, 2, 0, 0}));
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, 31'd3, 32'h1, 0, nil));
    // equal stamp lands after the existing one
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, 31'd3, 32'h2, 0, nil));
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, 31'd1, 32'hA5A5A5A5, 0, nil));
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, 31'h40000000, 32'h5A5A5A5A, 0, nil));
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, 31'd2, 32'h12345678, 0, nil));
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, 31'd2, 32'h87654321, 1,
                                '{rcht_pkg::ST_OK, 0, 8, 0, 0}));
    // bucket full refuses and reports the full count
    directed.push_back(make_row(rcht_pkg::CMD_INSERT, 31'd9, '1, 1,
                                '{rcht_pkg::ST_FULL, 0, 8, 0, 0}));
    directed.push_back(make_row(rcht_pkg::CMD_QUERY, 31'd3, 32'h0, 0, nil));
    directed.push_back(make_row(rcht_pkg::CMD_QUERY, 31'd2, 32'h0, 0, nil));
    directed.push_back(make_row(rcht_pkg::CMD_QUERY, '1, '1, 0, nil));
    directed.push_back(make_row(rcht_pkg::CMD_QUERY, 31'd0, 32'h0, 1,
                                '{rcht_pkg::ST_OK, 0, 8, '1, 0}));
    directed.push_back(make_row(rcht_pkg::CMD_QUERY, 31'd4, '1, 1,
                                '{rcht_pkg::ST_NOT_FOUND, 0, 8, 0, 0}));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // random phases: registers changed while idle, idling mode rotates
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(rcht_pkg::CFG_LOAD_FACTOR, 8'(phase_load[ph]));
      // table is not empty any more: size only gets stored
      write_reg(rcht_pkg::CFG_INITIAL_SIZE, (ph == 1) ? 8'd255 : 8'($urandom));
      idle_mode = ph % 4;
      for (int n = 0; n < PhaseItems; n++) send_item(random_item());
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
src/rcht_pkg.sv
src/rcht_ifs.sv
src/resizing_chained_hash_table.sv
tb/testbench.sv
